>>> hdl/per_channel_running_variance_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_RUNNING_VARIANCE_MACROS_SVH
`define PER_CHANNEL_RUNNING_VARIANCE_MACROS_SVH

// same-cycle implication
`define PCRV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCRV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pcrv_pkg.sv
// ----------------------------------------------------------------------------
// pcrv_pkg
// Widths, defaults, sequencer states and store entry type of the running
// variance block.
// ----------------------------------------------------------------------------
package pcrv_pkg;

  localparam int AMP_W          = 8;
  localparam int IDX_W          = 6;
  localparam int FRAC_BITS      = 16;
  localparam int MEAN_W         = 24;
  localparam int M2_W           = 50;
  localparam int VAR_W          = 31;
  localparam int FC_W           = 20;
  localparam int PROD_W         = 2 * MEAN_W;
  localparam int STEP_W         = 6;
  localparam int IDX_EXT_W      = 9;
  localparam int MEAN_STEPS     = MEAN_W;
  localparam int VAR_STEPS      = M2_W;
  localparam int DEF_NUM_SUB    = 56;
  localparam int DEF_COUNT_BITS = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_MEAN,
    ST_MUL,
    ST_ACC,
    ST_DIV_VAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [M2_W-1:0]   m2;
  } entry_t;

endpackage

>>> hdl/pcrv_if.sv
// ----------------------------------------------------------------------------
// pcrv_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface pcrv_in_if
  import pcrv_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [AMP_W-1:0] sample_amp;
  logic [IDX_W-1:0] sub_index;
  logic             frame_start;

  modport source (output valid, sample_amp, sub_index, frame_start, input ready);
  modport sink (input valid, sample_amp, sub_index, frame_start, output ready);
endinterface

interface pcrv_out_if
  import pcrv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  out_index;
  logic [MEAN_W-1:0] mean_value;
  logic [VAR_W-1:0]  sample_variance;
  logic [FC_W-1:0]   frame_count;

  modport source (output valid, out_index, mean_value, sample_variance, frame_count,
                  input ready);
  modport sink (input valid, out_index, mean_value, sample_variance, frame_count,
                output ready);
endinterface

>>> hdl/per_channel_running_variance.sv
// ----------------------------------------------------------------------------
// per_channel_running_variance
// Welford running mean and sample variance for each subcarrier channel.
// Channels: samples (sink) takes one amplitude word with its channel index
// and frame_start flag; results (source) returns one word per sample with
// the updated mean (8.16), the variance M2/(n-1) (15.16) and the frame count.
// Timing: one sample at a time; samples.ready is high only while idle. A
// word runs a 24-step mean division and, when the count exceeds one, a
// 50-step variance division; an out-of-range index skips both. The
// bit-serial divider, one quotient bit per cycle, is shared by both
// divisions.
// Reset: clears the frame count and all channel statistics at once; a
// sample may be taken in the cycle after reset.
// Stall: the finished word sits in the output register; the next sample is
// taken meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
`include "per_channel_running_variance_macros.svh"

module per_channel_running_variance
  import pcrv_pkg::*;
#(
  parameter int NUM_SUB    = DEF_NUM_SUB,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input logic        clk,
  input logic        rst,
  pcrv_in_if.sink    samples,
  pcrv_out_if.source results
);

  localparam int ADDR_W = (NUM_SUB > 1) ? $clog2(NUM_SUB) : 1;

  state_t                state, state_next;
  logic [COUNT_BITS-1:0] frames_seen;
  logic [AMP_W-1:0]      amp;
  logic [IDX_W-1:0]      idx;
  logic                  in_range;
  logic                  ge;
  logic [MEAN_W-1:0]     mean;
  logic [M2_W-1:0]       m2;
  logic [MEAN_W-1:0]     mag_d;
  logic [MEAN_W-1:0]     mag_e;
  logic [MEAN_W-1:0]     new_mean;
  logic [PROD_W-1:0]     prod;
  logic [VAR_W-1:0]      var_res;

  logic                  out_valid;
  logic [IDX_W-1:0]      out_idx;
  logic [MEAN_W-1:0]     out_mean;
  logic [VAR_W-1:0]      out_var;
  logic [FC_W-1:0]       out_fc;

  logic [IDX_EXT_W-1:0]  in_idx_ext;
  logic [IDX_EXT_W-1:0]  idx_ext;
  logic                  in_range_c;
  logic                  accept;
  logic                  out_load;
  logic [COUNT_BITS-1:0] frames_next;
  logic [COUNT_BITS-1:0] n_c;
  logic [MEAN_W-1:0]     x_c;
  logic [MEAN_W-1:0]     rd_x_c;
  logic [MEAN_W-1:0]     mag_d_c;
  logic [M2_W:0]         m2_sum;
  logic [M2_W-1:0]       m2_new;
  logic [MEAN_W-1:0]     q_mean;
  logic [31:0]           fs_wide;
  logic [FC_W-1:0]       fc_c;

  logic                  div_start;
  logic [STEP_W-1:0]     div_steps;
  logic [M2_W-1:0]       div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [M2_W-1:0]       div_quotient;

  logic                  st_rd;
  logic                  st_wr;
  entry_t                rd_entry;
  entry_t                wr_entry;

  pcrv_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  pcrv_store #(
    .NUM_SUB(NUM_SUB)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (st_rd),
    .rd_addr (in_idx_ext[ADDR_W-1:0]),
    .rd_data (rd_entry),
    .wr_en   (st_wr),
    .wr_addr (idx_ext[ADDR_W-1:0]),
    .wr_data (wr_entry)
  );

  always_comb begin
    in_idx_ext  = IDX_EXT_W'(samples.sub_index);
    idx_ext     = IDX_EXT_W'(idx);
    in_range_c  = in_idx_ext < IDX_EXT_W'(NUM_SUB);
    accept      = samples.valid && samples.ready;
    frames_next = (samples.frame_start && (frames_seen != '1))
                  ? frames_seen + COUNT_BITS'(1) : frames_seen;
    n_c         = (frames_seen == '0) ? COUNT_BITS'(1) : frames_seen;
    x_c         = {amp, {FRAC_BITS{1'b0}}};
    rd_x_c      = rd_entry.mean;
    mag_d_c     = (x_c >= rd_x_c) ? x_c - rd_x_c : rd_x_c - x_c;
    m2_sum      = {1'b0, m2} + (M2_W + 1)'(prod[PROD_W-1:FRAC_BITS]);
    m2_new      = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
    q_mean      = div_quotient[MEAN_W-1:0];
    fs_wide     = 32'(frames_seen);
    fc_c        = (fs_wide > 32'({FC_W{1'b1}})) ? '1 : fs_wide[FC_W-1:0];
    wr_entry    = '{mean: new_mean, m2: m2_new};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    st_rd         = 1'b0;
    st_wr         = 1'b0;
    div_start     = 1'b0;
    div_steps     = STEP_W'(MEAN_STEPS);
    div_dividend  = {mag_d_c, {(M2_W - MEAN_W){1'b0}}};
    div_divisor   = n_c;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = !rst;
        if (samples.valid) begin
          st_rd      = 1'b1;
          state_next = in_range_c ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        div_start  = 1'b1;
        state_next = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        st_wr = 1'b1;
        if (frames_seen > COUNT_BITS'(1)) begin
          div_start    = 1'b1;
          div_steps    = STEP_W'(VAR_STEPS);
          div_dividend = m2_new;
          div_divisor  = frames_seen - COUNT_BITS'(1);
          state_next   = ST_DIV_VAR;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV_VAR: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
    end else if (accept) begin
      frames_seen <= frames_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amp      <= samples.sample_amp;
      idx      <= samples.sub_index;
      in_range <= in_range_c;
      var_res  <= '0;
    end
    if (state == ST_READ) begin
      mean  <= rd_entry.mean;
      m2    <= rd_entry.m2;
      ge    <= x_c >= rd_x_c;
      mag_d <= mag_d_c;
    end
    if (state == ST_DIV_MEAN && div_done) begin
      new_mean <= ge ? mean + q_mean : mean - q_mean;
      mag_e    <= mag_d - q_mean;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(mag_d) * PROD_W'(mag_e);
    end
    if (state == ST_DIV_VAR && div_done) begin
      var_res <= (|div_quotient[M2_W-1:VAR_W]) ? '1 : div_quotient[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx  <= idx;
      out_mean <= in_range ? new_mean : '0;
      out_var  <= var_res;
      out_fc   <= fc_c;
    end
  end

  assign results.valid           = out_valid;
  assign results.out_index       = out_idx;
  assign results.mean_value      = out_mean;
  assign results.sample_variance = out_var;
  assign results.frame_count     = out_fc;

  `PCRV_ASSERT_NOW(a_done_in_div, div_done,
    (state == ST_DIV_MEAN) || (state == ST_DIV_VAR), "divider done outside a division")
  `PCRV_ASSERT_NEXT(a_load_valid, out_load, results.valid,
    "loaded result word not presented")
  `PCRV_ASSERT_NEXT(a_write_then_div, st_wr,
    (state == ST_DIV_VAR) || (state == ST_FINISH), "store write out of sequence")
  `PCRV_ASSERT_NOW(a_var_low_count, results.valid && (results.frame_count <= FC_W'(1)),
    results.sample_variance == '0, "nonzero variance with count of one or less")
  `PCRV_ASSERT_NOW(a_oor_mean,
    results.valid && (IDX_EXT_W'(results.out_index) >= IDX_EXT_W'(NUM_SUB)),
    results.mean_value == '0, "nonzero mean for out-of-range channel")

endmodule

>>> hdl/pcrv_div.sv
// ----------------------------------------------------------------------------
// pcrv_div
// Restoring divider, one quotient bit per cycle. The dividend is left aligned
// in the shift register; after k steps the low k bits hold the quotient.
// ----------------------------------------------------------------------------
module pcrv_div
  import pcrv_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [STEP_W-1:0]     steps,
  input  logic [M2_W-1:0]       dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [M2_W-1:0]       quotient
);

  logic                  busy;
  logic [STEP_W-1:0]     left;
  logic [M2_W-1:0]       shreg;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dsor;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;
  logic [COUNT_BITS-1:0] rem_next;

  always_comb begin
    trial    = {rem, shreg[M2_W-1]};
    diff     = trial - {1'b0, dsor};
    fits     = trial >= {1'b0, dsor};
    rem_next = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= steps;
      end else if (busy) begin
        left <= left - STEP_W'(1);
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dsor  <= divisor;
    end else if (busy) begin
      shreg <= {shreg[M2_W-2:0], fits};
      rem   <= rem_next;
    end
  end

  assign quotient = shreg;

endmodule

>>> hdl/pcrv_store.sv
// ----------------------------------------------------------------------------
// pcrv_store
// Per-channel mean and M2 memory with registered read. Valid bits cleared at
// reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module pcrv_store
  import pcrv_pkg::*;
#(
  parameter int NUM_SUB = DEF_NUM_SUB,
  localparam int ADDR_W = (NUM_SUB > 1) ? $clog2(NUM_SUB) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data
);

  entry_t             mem [NUM_SUB];
  logic [NUM_SUB-1:0] filled;
  entry_t             rd_q;
  logic               hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= filled[rd_addr];
      end
    end
  end

  assign rd_data = hit_q ? rd_q : '0;

endmodule

>>> bench/tb_per_channel_running_variance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_channel_running_variance
// Drives amplitude words into the running variance block and checks every
// result word against a Welford predictor kept alongside. A short directed
// run covers samples before the first frame, out-of-range channels, repeated
// channels and amplitude extremes; random frames follow under four idling
// phases, with one long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_per_channel_running_variance;
  import pcrv_pkg::*;

  localparam int NUM_CH = DEF_NUM_SUB;
  localparam longint unsigned COUNT_MAX = (64'd1 << DEF_COUNT_BITS) - 1;
  localparam longint unsigned M2_MAX = (64'd1 << M2_W) - 1;
  localparam longint unsigned VAR_MAX = (64'd1 << VAR_W) - 1;
  localparam int HOLD_LEN = 500;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 110;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [IDX_W-1:0] idx;
    logic             frame_start;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic [MEAN_W-1:0] mean_value;
    logic [VAR_W-1:0]  sample_variance;
    logic [FC_W-1:0]   frame_count;
  } stats_t;

  logic clk;
  logic rst;

  pcrv_in_if  samples_if ();
  pcrv_out_if results_if ();

  per_channel_running_variance uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  always #10 clk = ~clk;

  sample_t pending_samples[$];
  stats_t  expected_stats[$];

  logic [FC_W-1:0]   frames_seen;
  logic [MEAN_W-1:0] chan_mean [NUM_CH];
  logic [M2_W-1:0]   chan_m2 [NUM_CH];

  int send_idle_pct;
  int sink_stall_pct;
  int hold_requests;
  int holds_granted;
  int hold_left;
  int words_offered;
  int words_taken;
  int idle_cycles;
  int errors;

  function automatic stats_t welford_update(sample_t s);
    longint unsigned n, xfix, mu, mu_new, mag_d, mag_e, prod, m2, var_q;
    stats_t r;
    if (s.frame_start && frames_seen < COUNT_MAX) frames_seen = frames_seen + FC_W'(1);
    r = '0;
    r.out_index = s.idx;
    if (s.idx < NUM_CH) begin
      n = (frames_seen == 0) ? 64'd1 : 64'(frames_seen);
      xfix = 64'(s.amp) << FRAC_BITS;
      mu = 64'(chan_mean[s.idx]);
      if (xfix >= mu) begin
        mag_d = xfix - mu;
        mu_new = mu + mag_d / n;
        mag_e = xfix - mu_new;
      end else begin
        mag_d = mu - xfix;
        mu_new = mu - mag_d / n;
        mag_e = mu_new - xfix;
      end
      chan_mean[s.idx] = mu_new[MEAN_W-1:0];
      prod = (mag_d * mag_e) >> FRAC_BITS;
      m2 = 64'(chan_m2[s.idx]);
      m2 = (prod > M2_MAX - m2) ? M2_MAX : m2 + prod;
      chan_m2[s.idx] = m2[M2_W-1:0];
      r.mean_value = mu_new[MEAN_W-1:0];
      if (frames_seen > 1) begin
        var_q = m2 / (64'(frames_seen) - 64'd1);
        if (var_q > VAR_MAX) var_q = VAR_MAX;
        r.sample_variance = var_q[VAR_W-1:0];
      end
    end
    r.frame_count = frames_seen;
    return r;
  endfunction

  task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic push_sample(int amp, int idx, bit fs);
    sample_t s;
    s.amp = AMP_W'(amp);
    s.idx = IDX_W'(idx);
    s.frame_start = fs;
    pending_samples.push_back(s);
  endtask

  task automatic queue_directed();
    push_sample(255, 0, 0);
    push_sample(0, 63, 0);
    push_sample(128, 55, 0);
    push_sample(0, 0, 1);
    push_sample(255, 0, 0);
    push_sample(255, 55, 0);
    push_sample(77, 56, 0);
    push_sample(0, 1, 0);
    push_sample(200, 63, 1);
    push_sample(255, 1, 0);
    push_sample(0, 0, 0);
    push_sample(255, 0, 0);
    push_sample(0, 55, 0);
    push_sample(170, 42, 1);
    push_sample(85, 21, 0);
    push_sample(255, 1, 0);
    push_sample(0, 1, 0);
    push_sample(1, 2, 1);
    push_sample(254, 2, 0);
    push_sample(255, 57, 1);
  endtask

  task automatic queue_frames(int count);
    int left, frame_len, amp, idx, pick;
    bit fs;
    left = count;
    while (left > 0) begin
      frame_len = $urandom_range(1, 16);
      for (int k = 0; k < frame_len && left > 0; k++) begin
        pick = $urandom_range(99);
        fs = (k == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 4);
        idx = (pick < 90) ? $urandom_range(0, NUM_CH - 1) : $urandom_range(NUM_CH, 63);
        pick = $urandom_range(99);
        if (pick < 6) amp = 0;
        else if (pick < 12) amp = 255;
        else amp = $urandom_range(0, 255);
        push_sample(amp, idx, fs);
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || samples_if.valid || expected_stats.size() != 0)
      @(posedge clk);
  endtask

  // drive sample words
  always @(negedge clk) begin : drive_samples
    sample_t s;
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else if (samples_if.valid && words_taken != words_offered) begin
      samples_if.valid <= 1'b1;
    end else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s = pending_samples.pop_front();
      samples_if.sample_amp <= s.amp;
      samples_if.sub_index <= s.idx;
      samples_if.frame_start <= s.frame_start;
      samples_if.valid <= 1'b1;
      words_offered <= words_offered + 1;
    end else begin
      samples_if.valid <= 1'b0;
    end
  end

  // drive result ready, with the long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted <= hold_requests;
      hold_left <= HOLD_LEN;
      results_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // accept, predict, compare
  always @(posedge clk) begin : monitor
    sample_t s_in;
    stats_t  exp_r;
    logic    fired;
    if (!rst) begin
      fired = 1'b0;
      if (results_if.valid && results_if.ready) begin
        fired = 1'b1;
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result word: index %0d mean %0d variance %0d count %0d",
                   $time, results_if.out_index, results_if.mean_value,
                   results_if.sample_variance, results_if.frame_count);
          errors++;
        end else begin
          exp_r = expected_stats.pop_front();
          report_field("out_index", exp_r.out_index, results_if.out_index);
          report_field("mean_value", exp_r.mean_value, results_if.mean_value);
          report_field("sample_variance", exp_r.sample_variance, results_if.sample_variance);
          report_field("frame_count", exp_r.frame_count, results_if.frame_count);
        end
      end
      if (samples_if.valid && samples_if.ready) begin
        fired = 1'b1;
        s_in.amp = samples_if.sample_amp;
        s_in.idx = samples_if.sub_index;
        s_in.frame_start = samples_if.frame_start;
        expected_stats.push_back(welford_update(s_in));
        words_taken <= words_taken + 1;
      end
      idle_cycles <= fired ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.sample_amp = '0;
    samples_if.sub_index = '0;
    samples_if.frame_start = 1'b0;
    results_if.ready = 1'b0;
    frames_seen = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_mean[i] = '0;
      chan_m2[i] = '0;
    end
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_requests = 0;
    holds_granted = 0;
    hold_left = 0;
    words_offered = 0;
    words_taken = 0;
    idle_cycles = 0;
    errors = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_directed();
    queue_frames(RANDOM_PER_PHASE);
    hold_requests = hold_requests + 1;
    wait_drained();

    for (int phase = 1; phase < 4; phase++) begin
      case (phase)
        1: begin
          send_idle_pct = 84;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          sink_stall_pct = 84;
        end
        default: begin
          send_idle_pct = 17;
          sink_stall_pct = 17;
        end
      endcase
      queue_frames(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
